>>> design/wola_pkg.sv
// Package for the weighted overlap-add synthesis block.
// Fixed field widths, configuration register indexes and reset values, item kind codes, rounding shift and stage type.
// No dependencies.
package wola_pkg;

  // Field widths of the item, result and configuration channels
  localparam int POS_W = 9;
  localparam int SMP_W = 24;
  localparam int WGT_W = 18;
  localparam int CFG_W = 10;
  localparam int CH_CFG_W = 2;
  localparam int CHC_W = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FFT_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] FFT_LEN_RST = 10'd512;
  localparam logic [CFG_W-1:0] HOP_SIZE_RST = 10'd128;
  localparam logic [CH_CFG_W-1:0] CHANNELS_RST = 2'd2;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Rounding shift for the Q3.39 to Q.23 step
  localparam int RND_SHIFT = 16;

  // Per-stage control of one frame sample
  typedef struct packed {
    logic emit;
    logic last;
    logic zero;
    logic ch;
    logic [POS_W-1:0] pos;
  } stage_ctl_t;

endpackage

>>> design/weighted_overlap_add_synthesis.sv
// Top level of the weighted overlap-add synthesis block: window weighting,
// per-channel circular overlap buffer in block memory, saturating accumulate.
// Depends on wola_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   kind, position, channel, sample, weight
//   out      source     out_valid_o / out_stall_i out_channel, out_position, out_sample,
//                                                 clipped, last
//   cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; a frame sample below the hop yields a result.
// Pipeline: memory read (window and overlap slot), multiply, accumulate and write back.
// After reset the overlap buffer is cleared, one entry a cycle, all CHANNELS*FRAME_MAX
// entries (1024 at the defaults), with in_stall_o high.
// A write of fft_len outside the clearing pass starts a base reduction with in_stall_o
// high, one conditional subtract per slot bit. A stalled output freezes the whole pipeline.
module weighted_overlap_add_synthesis #(
  parameter int FRAME_MAX = 512,
  parameter int CHANNELS = 2,
  parameter int ACC_BITS = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration
  input  logic cfg_we_i,
  input  logic [wola_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wola_pkg::CFG_W-1:0] cfg_data_i,
  // item input
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic kind_i,
  input  logic [wola_pkg::POS_W-1:0] position_i,
  input  logic channel_i,
  input  logic signed [wola_pkg::SMP_W-1:0] sample_i,
  input  logic [wola_pkg::WGT_W-1:0] weight_i,
  // result output
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic out_channel_o,
  output logic [wola_pkg::POS_W-1:0] out_position_o,
  output logic signed [wola_pkg::SMP_W-1:0] out_sample_o,
  output logic clipped_o,
  output logic last_o
);

  localparam int SLOT_W = $clog2(FRAME_MAX);
  localparam int BUF_DEPTH = CHANNELS * FRAME_MAX;
  localparam int BUF_AW = $clog2(BUF_DEPTH);
  localparam int LEN_W = $clog2(FRAME_MAX + 1);
  localparam int CW = ((LEN_W > wola_pkg::CFG_W) ? LEN_W : wola_pkg::CFG_W) + 2;
  localparam int RW = CW + SLOT_W;
  localparam int KW = $clog2(SLOT_W);
  localparam int PROD_W = wola_pkg::SMP_W + wola_pkg::WGT_W + 1;
  localparam int RND_W = PROD_W - wola_pkg::RND_SHIFT;
  localparam int SUM_W = ((ACC_BITS > RND_W) ? ACC_BITS : RND_W) + 1;
  localparam int CHC_W = wola_pkg::CHC_W;

  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);
  localparam logic signed [ACC_BITS-1:0] OUT_MAX =
    ACC_BITS'((64'sd1 <<< (wola_pkg::SMP_W - 1)) - 64'sd1);
  localparam logic signed [ACC_BITS-1:0] OUT_MIN = -OUT_MAX - ACC_BITS'(1);
  localparam logic signed [PROD_W-1:0] RND_HALF =
    PROD_W'(64'sd1 <<< (wola_pkg::RND_SHIFT - 1));

  // Sequencer codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_REDUCE = 2'd2;

  // Memories
  logic [wola_pkg::WGT_W-1:0] win_mem [FRAME_MAX];
  logic signed [ACC_BITS-1:0] buf_mem [BUF_DEPTH];

  // Configuration and control registers
  logic [wola_pkg::CFG_W-1:0] fft_len_q, hop_size_q;
  logic [wola_pkg::CH_CFG_W-1:0] chans_cfg_q;
  logic [1:0] state_q, state_d;
  logic [BUF_AW-1:0] clr_q, clr_d;
  logic [KW-1:0] k_q, k_d;
  logic [SLOT_W-1:0] base_q, base_d;
  logic v1_q, v2_q, out_valid_q;

  // Payload registers
  logic [wola_pkg::WGT_W-1:0] win_rd_q;
  logic signed [ACC_BITS-1:0] buf_rd_q, fwdd1_q, buf2_q;
  logic fwd1_q;
  wola_pkg::stage_ctl_t ctl1_q, ctl2_q;
  logic [BUF_AW-1:0] idx1_q, idx2_q;
  logic signed [wola_pkg::SMP_W-1:0] smp1_q;
  logic signed [PROD_W-1:0] prod2_q;
  logic out_channel_q, clipped_q, last_q;
  logic [wola_pkg::POS_W-1:0] out_position_q;
  logic signed [wola_pkg::SMP_W-1:0] out_sample_q;

  // Combinational signals
  logic en, accept, smp_ok, frame_end, win_we, s2_wr;
  logic [CW-1:0] len_c, hop_c, pos_c, bh, bh_m, sl, sl_m;
  logic [CHC_W-1:0] chans_c;
  logic [SLOT_W-1:0] slot;
  logic [BUF_AW-1:0] idx;
  wola_pkg::stage_ctl_t ctl0;
  logic [RW-1:0] red_sub;
  logic signed [PROD_W-1:0] mul_c, rnd_full;
  logic signed [RND_W-1:0] prodr;
  logic signed [ACC_BITS-1:0] base_val, acc_sat, out_sat;
  logic signed [SUM_W-1:0] sum;
  logic hit_acc, hit_out;
  logic buf_we;
  logic [BUF_AW-1:0] buf_waddr;
  logic signed [ACC_BITS-1:0] buf_wdata;

  // Handshake
  assign en = !(out_valid_q && out_stall_i);
  assign in_stall_o = (state_q != ST_RUN) || !en;
  assign accept = in_valid_i && !in_stall_o;

  // Effective frame length, hop and channel count
  always_comb begin
    len_c = (CW'(fft_len_q) > CW'(FRAME_MAX)) ? CW'(FRAME_MAX) : CW'(fft_len_q);
    hop_c = (CW'(hop_size_q) > len_c) ? len_c : CW'(hop_size_q);
    if (chans_cfg_q == '0) begin
      chans_c = CHC_W'(1);
    end else if (CHC_W'(chans_cfg_q) > CHC_W'(CHANNELS)) begin
      chans_c = CHC_W'(CHANNELS);
    end else begin
      chans_c = CHC_W'(chans_cfg_q);
    end
  end

  // Slot address: (base + hop + position) mod len, two conditional subtracts
  always_comb begin
    pos_c = CW'(position_i);
    bh = CW'(base_q) + hop_c;
    bh_m = (bh >= len_c) ? bh - len_c : bh;
    sl = bh_m + pos_c;
    sl_m = (sl >= len_c) ? sl - len_c : sl;
    slot = SLOT_W'(sl_m);
    idx = channel_i ? BUF_AW'(FRAME_MAX) + BUF_AW'(slot) : BUF_AW'(slot);
    smp_ok = (kind_i == wola_pkg::KIND_SAMPLE) && (len_c != '0) && (pos_c < len_c)
             && (CHC_W'(channel_i) < chans_c);
    frame_end = (pos_c == len_c - CW'(1)) && (CHC_W'(channel_i) == chans_c - CHC_W'(1))
                && (hop_c != '0);
    win_we = accept && (kind_i == wola_pkg::KIND_LOAD) && (pos_c < CW'(FRAME_MAX));
    ctl0.emit = pos_c < hop_c;
    ctl0.last = (pos_c == hop_c - CW'(1)) && (CHC_W'(channel_i) == chans_c - CHC_W'(1));
    ctl0.zero = pos_c >= len_c - hop_c;
    ctl0.ch = channel_i;
    ctl0.pos = position_i;
  end

  // Multiply stage
  assign mul_c = $signed(smp1_q) * $signed({1'b0, win_rd_q});

  // Accumulate stage: round, add, saturate twice
  always_comb begin
    rnd_full = prod2_q + RND_HALF;
    prodr = rnd_full[PROD_W-1:wola_pkg::RND_SHIFT];
    base_val = ctl2_q.zero ? '0 : buf2_q;
    sum = SUM_W'(base_val) + SUM_W'(prodr);
    hit_acc = 1'b0;
    if (sum > ACC_MAX) begin
      acc_sat = ACC_MAX[ACC_BITS-1:0];
      hit_acc = 1'b1;
    end else if (sum < ACC_MIN) begin
      acc_sat = ACC_MIN[ACC_BITS-1:0];
      hit_acc = 1'b1;
    end else begin
      acc_sat = sum[ACC_BITS-1:0];
    end
    hit_out = 1'b0;
    if (acc_sat > OUT_MAX) begin
      out_sat = OUT_MAX;
      hit_out = 1'b1;
    end else if (acc_sat < OUT_MIN) begin
      out_sat = OUT_MIN;
      hit_out = 1'b1;
    end else begin
      out_sat = acc_sat;
    end
  end

  assign s2_wr = en && v2_q;

  // Buffer write port: clearing pass or writeback
  always_comb begin
    if (state_q == ST_CLEAR) begin
      buf_we = 1'b1;
      buf_waddr = clr_q;
      buf_wdata = '0;
    end else begin
      buf_we = s2_wr;
      buf_waddr = idx2_q;
      buf_wdata = acc_sat;
    end
  end

  // Window table
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[SLOT_W'(position_i)] <= weight_i;
    end
    if (accept) begin
      win_rd_q <= win_mem[SLOT_W'(position_i)];
    end
  end

  // Overlap buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    if (accept) begin
      buf_rd_q <= buf_mem[idx];
    end
  end

  // Sequencer: clear after reset, base reduction after a length change
  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    k_d = k_q;
    base_d = base_q;
    red_sub = RW'(len_c) << k_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + BUF_AW'(1);
        if (clr_q == BUF_AW'(BUF_DEPTH - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept && smp_ok && frame_end) begin
          base_d = SLOT_W'(bh_m);
        end
      end
      ST_REDUCE: begin
        if (RW'(base_q) >= red_sub) begin
          base_d = SLOT_W'(RW'(base_q) - red_sub);
        end
        k_d = k_q - KW'(1);
        if (k_q == '0) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
    if (cfg_we_i && (cfg_index_i == wola_pkg::CFG_FFT_LEN) && (state_q != ST_CLEAR)) begin
      state_d = ST_REDUCE;
      k_d = KW'(SLOT_W - 1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      k_q <= '0;
      base_q <= '0;
      fft_len_q <= wola_pkg::FFT_LEN_RST;
      hop_size_q <= wola_pkg::HOP_SIZE_RST;
      chans_cfg_q <= wola_pkg::CHANNELS_RST;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      k_q <= k_d;
      base_q <= base_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          wola_pkg::CFG_FFT_LEN: fft_len_q <= cfg_data_i;
          wola_pkg::CFG_HOP_SIZE: hop_size_q <= cfg_data_i;
          wola_pkg::CFG_CHANNELS: chans_cfg_q <= cfg_data_i[wola_pkg::CH_CFG_W-1:0];
          default: ;
        endcase
      end
      if (en) begin
        v1_q <= accept && smp_ok;
        v2_q <= v1_q;
        out_valid_q <= v2_q && ctl2_q.emit;
      end
    end
  end

  // Pipeline payload with forwarding of in-flight writebacks
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl1_q <= ctl0;
      idx1_q <= idx;
      smp1_q <= sample_i;
      fwd1_q <= s2_wr && (idx2_q == idx);
      fwdd1_q <= acc_sat;
      ctl2_q <= ctl1_q;
      idx2_q <= idx1_q;
      prod2_q <= mul_c;
      if (s2_wr && (idx2_q == idx1_q)) begin
        buf2_q <= acc_sat;
      end else if (fwd1_q) begin
        buf2_q <= fwdd1_q;
      end else begin
        buf2_q <= buf_rd_q;
      end
      if (v2_q && ctl2_q.emit) begin
        out_channel_q <= ctl2_q.ch;
        out_position_q <= ctl2_q.pos;
        out_sample_q <= out_sat[wola_pkg::SMP_W-1:0];
        clipped_q <= hit_acc || hit_out;
        last_q <= ctl2_q.last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign out_position_o = out_position_q;
  assign out_sample_o = out_sample_q;
  assign clipped_o = clipped_q;
  assign last_o = last_q;

`ifndef SYNTHESIS
  // No item is taken during the clearing pass or a base reduction
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> in_stall_o) else $error("item taken while busy");

  // The base stays reduced modulo the frame length while items flow
  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && (len_c != '0)) |-> (CW'(base_q) < len_c))
    else $error("frame base not below frame length");

  // Clearing writes never collide with pipeline writebacks
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!v1_q && !v2_q)) else $error("pipeline busy in clear");

  // A result only appears after the accumulate stage held a sample
  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v2_q)) else $error("result without sample");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for weighted_overlap_add_synthesis: directed table, then random frames.
// Predicts the windowed overlap-add output in SystemVerilog and checks every output item.
// Depends on wola_pkg and the weighted_overlap_add_synthesis top level.
module testbench;

  localparam int FRAME_MAX = 512;
  localparam int CHANNELS = 2;
  localparam int ACC_BITS = 28;
  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int POS_W = wola_pkg::POS_W;
  localparam int SMP_W = wola_pkg::SMP_W;
  localparam int WGT_W = wola_pkg::WGT_W;
  localparam int CFG_W = wola_pkg::CFG_W;
  localparam int CH_CFG_W = wola_pkg::CH_CFG_W;
  localparam int CFG_IDX_W = wola_pkg::CFG_IDX_W;
  localparam int RND_SHIFT = wola_pkg::RND_SHIFT;
  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic [WGT_W-1:0] WGT_MAX = '1;
  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1 << RND_SHIFT);

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_OUT} check_e;

  typedef struct {
    logic kind;
    logic [POS_W-1:0] pos;
    logic ch;
    logic signed [SMP_W-1:0] smp;
    logic [WGT_W-1:0] weight;
  } frame_item_t;

  typedef struct {
    logic ch;
    logic [POS_W-1:0] pos;
    logic signed [SMP_W-1:0] smp;
    logic clipped;
    logic last;
  } synth_out_t;

  typedef struct {
    bit is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0] val;
    frame_item_t it;
    check_e chk;
    synth_out_t want;
  } plan_row_t;

  // DUT ports, inputs driven to known values from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = 1'b0;
  logic [POS_W-1:0] position_i = '0;
  logic channel_i = 1'b0;
  logic signed [SMP_W-1:0] sample_i = '0;
  logic [WGT_W-1:0] weight_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic out_channel_o;
  logic [POS_W-1:0] out_position_o;
  logic signed [SMP_W-1:0] out_sample_o;
  logic clipped_o;
  logic last_o;

  // Predictor state: register copies, window table, overlap buffer, frame base
  logic [CFG_W-1:0] cfg_len;
  logic [CFG_W-1:0] cfg_hop;
  logic [CH_CFG_W-1:0] cfg_chans;
  logic [WGT_W-1:0] weight_mem [FRAME_MAX];
  logic signed [ACC_BITS-1:0] overlap_mem [CHANNELS*FRAME_MAX];
  int base_ptr;

  synth_out_t synth_due [$];
  synth_out_t blank_out;
  plan_row_t plan [$];
  int mismatches = 0;
  int accepted_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int run_left = 0;
  bit drain_req = 1'b0;
  bit calm = 1'b0;
  bit loud = 1'b0;
  bit loud_neg = 1'b0;

  weighted_overlap_add_synthesis #(
    .FRAME_MAX(FRAME_MAX),
    .CHANNELS(CHANNELS),
    .ACC_BITS(ACC_BITS)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .kind_i(kind_i),
    .position_i(position_i),
    .channel_i(channel_i),
    .sample_i(sample_i),
    .weight_i(weight_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_channel_o(out_channel_o),
    .out_position_o(out_position_o),
    .out_sample_o(out_sample_o),
    .clipped_o(clipped_o),
    .last_o(last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Effective frame length, hop and channel count from the register copies
  function automatic void frame_geom(output int len, output int hop, output int chans);
    len = (cfg_len < FRAME_MAX) ? int'(cfg_len) : FRAME_MAX;
    hop = (cfg_hop < len) ? int'(cfg_hop) : len;
    chans = (cfg_chans == 0) ? 1 : int'(cfg_chans);
    if (chans > CHANNELS) chans = CHANNELS;
  endfunction

  function automatic longint clamp_signed(input longint v, input int bits, inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Load a weight, or weight a sample, accumulate into the overlap slot, emit the first hop positions
  function automatic bit synth_predict(input frame_item_t it, output synth_out_t res);
    int len;
    int hop;
    int chans;
    int slot;
    int idx;
    longint prod;
    longint acc;
    longint outv;
    bit hit;
    hit = 1'b0;
    res = blank_out;
    if (it.kind == wola_pkg::KIND_LOAD) begin
      weight_mem[it.pos] = it.weight;
      return 1'b0;
    end
    frame_geom(len, hop, chans);
    if (len == 0 || int'(it.pos) >= len || int'(it.ch) >= chans) return 1'b0;
    // Q3.39 product rounded to Q.23, floor shift
    prod = (longint'(it.smp) * longint'(weight_mem[it.pos]) + (longint'(1) <<< (RND_SHIFT - 1)))
           >>> RND_SHIFT;
    slot = (base_ptr + hop + int'(it.pos)) % len;
    idx = int'(it.ch) * FRAME_MAX + slot;
    acc = (int'(it.pos) >= len - hop) ? longint'(0) : longint'(overlap_mem[idx]);
    acc = clamp_signed(acc + prod, ACC_BITS, hit);
    overlap_mem[idx] = acc[ACC_BITS-1:0];
    if (int'(it.pos) == len - 1 && int'(it.ch) == chans - 1 && hop > 0)
      base_ptr = (base_ptr + hop) % len;
    if (int'(it.pos) >= hop) return 1'b0;
    outv = clamp_signed(acc, SMP_W, hit);
    res.ch = it.ch;
    res.pos = it.pos;
    res.smp = outv[SMP_W-1:0];
    res.clipped = hit;
    res.last = (int'(it.pos) == hop - 1 && int'(it.ch) == chans - 1);
    return 1'b1;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [SMP_W-1:0] draw_smp();
    int roll;
    if (loud) return loud_neg ? SMP_MIN : SMP_MAX;
    roll = $urandom_range(0, 99);
    if (roll < 10) return SMP_MAX;
    if (roll < 20) return SMP_MIN;
    if (roll < 25) return '0;
    if (roll < 28) return '1;
    return SMP_W'($urandom);
  endfunction

  function automatic logic [WGT_W-1:0] draw_wgt();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return WGT_MAX;
    return WGT_W'($urandom);
  endfunction

  function automatic void check_field(input string name, input logic signed [SMP_W-1:0] want,
                                      input logic signed [SMP_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Drive one item at a falling edge, hold until accepted, then predict
  task automatic send_item(input frame_item_t it, input check_e chk, input synth_out_t want);
    int gap;
    bit has_res;
    synth_out_t res;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i <= it.kind;
    position_i <= it.pos;
    channel_i <= it.ch;
    sample_i <= it.smp;
    weight_i <= it.weight;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_res = synth_predict(it, res);
    if (chk == CHK_OUT) synth_due.push_back(want);
    else if (chk == CHK_MODEL && has_res) synth_due.push_back(res);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      wola_pkg::CFG_FFT_LEN: cfg_len = val;
      wola_pkg::CFG_HOP_SIZE: cfg_hop = val;
      wola_pkg::CFG_CHANNELS: cfg_chans = val[CH_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // Stop input, let every expected item out and the pipeline run empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain_req = 1'b1;
    while (synth_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    row.chk = CHK_NONE;
    plan.push_back(row);
  endtask

  task automatic plan_item(input logic kind, input int pos, input logic ch,
                           input logic signed [SMP_W-1:0] smp, input logic [WGT_W-1:0] weight,
                           input check_e chk, input logic signed [SMP_W-1:0] want_smp,
                           input logic want_clip, input logic want_last);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.it.kind = kind;
    row.it.pos = POS_W'(pos);
    row.it.ch = ch;
    row.it.smp = smp;
    row.it.weight = weight;
    row.chk = chk;
    row.want.ch = ch;
    row.want.pos = POS_W'(pos);
    row.want.smp = want_smp;
    row.want.clipped = want_clip;
    row.want.last = want_last;
    plan.push_back(row);
  endtask

  // One random configuration followed by well-formed frames with some noise
  task automatic run_phase(input bit full_len);
    logic [CFG_W-1:0] len_v;
    logic [CFG_W-1:0] hop_v;
    logic [CH_CFG_W-1:0] chan_v;
    int len;
    int hop;
    int chans;
    int lcap;
    int budget;
    int sent;
    int roll;
    int p;
    int c;
    frame_item_t it;
    if (full_len) begin
      len_v = $urandom_range(0, 1) ? CFG_W'(FRAME_MAX)
                                   : CFG_W'($urandom_range(FRAME_MAX + 1, 1023));
      hop_v = CFG_W'($urandom_range(1, FRAME_MAX));
      chan_v = CH_CFG_W'($urandom_range(0, 1));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) len_v = CFG_W'($urandom_range(4, 12));
      else if (roll < 88) len_v = CFG_W'($urandom_range(13, 64));
      else if (roll < 95) len_v = CFG_W'($urandom_range(65, 160));
      else len_v = CFG_W'($urandom_range(0, 3));
      lcap = (len_v == 0) ? 1 : int'(len_v);
      roll = $urandom_range(0, 99);
      if (roll < 7) hop_v = '0;
      else if (roll < 14) hop_v = CFG_W'($urandom_range(lcap, 1023));
      else if (roll < 45) hop_v = CFG_W'($urandom_range(1, (lcap < 2) ? lcap : 2));
      else hop_v = CFG_W'($urandom_range(1, lcap));
      chan_v = CH_CFG_W'($urandom_range(0, 3));
    end
    settle();
    write_reg(wola_pkg::CFG_CHANNELS, CFG_W'(chan_v));
    write_reg(wola_pkg::CFG_HOP_SIZE, hop_v);
    write_reg(wola_pkg::CFG_FFT_LEN, len_v);
    drain_req = 1'b0;
    calm = ($urandom_range(0, 3) == 0);
    loud = ($urandom_range(0, 3) == 0);
    loud_neg = 1'($urandom_range(0, 1));
    frame_geom(len, hop, chans);
    budget = full_len ? 1 : $urandom_range(60, 160);
    it.kind = wola_pkg::KIND_SAMPLE;
    // Zero frame length: everything is dropped
    if (len == 0) begin
      repeat (6) begin
        it.pos = POS_W'($urandom);
        it.ch = 1'($urandom_range(0, 1));
        it.smp = draw_smp();
        it.weight = draw_wgt();
        send_item(it, CHK_MODEL, blank_out);
      end
      return;
    end
    sent = 0;
    while (sent < budget) begin
      for (p = 0; p < len; p++) begin
        for (c = 0; c < chans; c++) begin
          roll = $urandom_range(0, 99);
          if (roll < 3) continue;
          if (roll < 6) begin
            // mid-stream weight reload
            it.kind = wola_pkg::KIND_LOAD;
            it.pos = POS_W'($urandom);
            it.ch = 1'($urandom_range(0, 1));
            it.smp = SMP_W'($urandom);
            it.weight = draw_wgt();
            send_item(it, CHK_MODEL, blank_out);
            sent++;
          end else if (roll < 9 && (len < FRAME_MAX || chans < CHANNELS)) begin
            // sample outside the frame, dropped
            it.kind = wola_pkg::KIND_SAMPLE;
            it.pos = (len < FRAME_MAX) ? POS_W'($urandom_range(len, FRAME_MAX - 1))
                                       : POS_W'($urandom);
            it.ch = (chans < CHANNELS) ? 1'b1 : 1'($urandom_range(0, 1));
            it.smp = draw_smp();
            it.weight = draw_wgt();
            send_item(it, CHK_MODEL, blank_out);
          end
          it.kind = wola_pkg::KIND_SAMPLE;
          it.pos = POS_W'(p);
          it.ch = 1'(c);
          it.smp = draw_smp();
          it.weight = WGT_W'($urandom);
          send_item(it, CHK_MODEL, blank_out);
          sent++;
        end
      end
    end
    accepted_count += sent;
  endtask

  // Output stall: random runs of stall and flow, released while draining
  always @(negedge clk_i) begin : out_stall_gen
    if (drain_req || calm || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0 && run_left == 0) begin
        stall_left = idle_len();
        run_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        run_left--;
      end
    end
  end

  // Compare each accepted output item with the oldest expectation
  always @(posedge clk_i) begin : out_check
    synth_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (synth_due.size() == 0) begin
        $display("%0t: unexpected output item ch=%0d pos=%0d sample=%0d", $time,
                 out_channel_o, out_position_o, out_sample_o);
        mismatches++;
      end else begin
        want = synth_due.pop_front();
        check_field("out_channel", want.ch, out_channel_o);
        check_field("out_position", want.pos, out_position_o);
        check_field("out_sample", want.smp, out_sample_o);
        check_field("clipped", want.clipped, clipped_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : main
    frame_item_t it;
    int i;
    foreach (overlap_mem[k]) overlap_mem[k] = '0;
    cfg_len = wola_pkg::FFT_LEN_RST;
    cfg_hop = wola_pkg::HOP_SIZE_RST;
    cfg_chans = wola_pkg::CHANNELS_RST;
    base_ptr = 0;
    blank_out = '{default: '0};

    // Directed table; defaults are L=512, H=128, two channels
    plan_item(wola_pkg::KIND_LOAD, 0, 1'b0, '0, WGT_ONE, CHK_NONE, '0, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_LOAD, 1, 1'b1, SMP_MIN, WGT_MAX, CHK_NONE, '0, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_LOAD, 2, 1'b0, SMP_MAX, '0, CHK_NONE, '0, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_LOAD, 3, 1'b0, '0, WGT_ONE, CHK_NONE, '0, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_LOAD, 511, 1'b1, '1, WGT_MAX, CHK_NONE, '0, 1'b0, 1'b0);
    // unity weight passes full scale through
    plan_item(wola_pkg::KIND_SAMPLE, 0, 1'b0, SMP_MAX, '0, CHK_OUT, SMP_MAX, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_SAMPLE, 0, 1'b1, SMP_MIN, '0, CHK_OUT, SMP_MIN, 1'b0, 1'b0);
    // maximum weight saturates the output both ways
    plan_item(wola_pkg::KIND_SAMPLE, 1, 1'b0, SMP_MAX, '0, CHK_OUT, SMP_MAX, 1'b1, 1'b0);
    plan_item(wola_pkg::KIND_SAMPLE, 1, 1'b1, SMP_MIN, '0, CHK_OUT, SMP_MIN, 1'b1, 1'b0);
    plan_item(wola_pkg::KIND_SAMPLE, 2, 1'b0, 24'sh123456, '0, CHK_OUT, '0, 1'b0, 1'b0);
    // end of frame, beyond the hop: no output, base moves
    plan_item(wola_pkg::KIND_SAMPLE, 511, 1'b1, SMP_MAX, '0, CHK_NONE, '0, 1'b0, 1'b0);
    plan_cfg(wola_pkg::CFG_CHANNELS, 10'd1);
    plan_item(wola_pkg::KIND_SAMPLE, 0, 1'b1, SMP_MAX, '0, CHK_NONE, '0, 1'b0, 1'b0);
    // shortest frame with hop equal to length, base carried over from L=512 and reduced
    plan_cfg(wola_pkg::CFG_HOP_SIZE, 10'd4);
    plan_cfg(wola_pkg::CFG_FFT_LEN, 10'd4);
    plan_item(wola_pkg::KIND_SAMPLE, 3, 1'b0, 24'sh400000, '0, CHK_OUT, 24'sh400000, 1'b0, 1'b1);
    plan_item(wola_pkg::KIND_SAMPLE, 4, 1'b0, SMP_MAX, '0, CHK_NONE, '0, 1'b0, 1'b0);
    plan_cfg(wola_pkg::CFG_HOP_SIZE, 10'd1);
    plan_item(wola_pkg::KIND_SAMPLE, 0, 1'b0, SMP_MAX, '0, CHK_MODEL, '0, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_SAMPLE, 1, 1'b0, SMP_MAX, '0, CHK_MODEL, '0, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_SAMPLE, 2, 1'b0, SMP_MIN, '0, CHK_MODEL, '0, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_SAMPLE, 3, 1'b0, 24'sh0F0F0F, '0, CHK_MODEL, '0, 1'b0, 1'b0);
    // zero hop: nothing leaves, base holds
    plan_cfg(wola_pkg::CFG_HOP_SIZE, 10'd0);
    plan_item(wola_pkg::KIND_SAMPLE, 0, 1'b0, SMP_MAX, '0, CHK_NONE, '0, 1'b0, 1'b0);
    plan_item(wola_pkg::KIND_SAMPLE, 3, 1'b0, SMP_MIN, '0, CHK_NONE, '0, 1'b0, 1'b0);
    // register values outside their useful range
    plan_cfg(wola_pkg::CFG_HOP_SIZE, 10'd1023);
    plan_cfg(wola_pkg::CFG_CHANNELS, 10'd3);
    plan_cfg(wola_pkg::CFG_FFT_LEN, 10'd0);
    plan_item(wola_pkg::KIND_SAMPLE, 0, 1'b0, SMP_MAX, '0, CHK_NONE, '0, 1'b0, 1'b0);
    plan_cfg(wola_pkg::CFG_FFT_LEN, 10'd1023);
    plan_item(wola_pkg::KIND_SAMPLE, 511, 1'b1, SMP_MIN, '0, CHK_OUT, SMP_MIN, 1'b1, 1'b1);
    plan_cfg(wola_pkg::CFG_CHANNELS, 10'd0);
    plan_item(wola_pkg::KIND_SAMPLE, 0, 1'b0, 24'sh000001, '0, CHK_MODEL, '0, 1'b0, 1'b0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        settle();
        write_reg(plan[r].idx, plan[r].val);
        drain_req = 1'b0;
      end else begin
        send_item(plan[r].it, plan[r].chk, plan[r].want);
      end
    end

    // Fill the whole window table before random frames read it
    it.kind = wola_pkg::KIND_LOAD;
    for (i = 0; i < FRAME_MAX; i++) begin
      it.pos = POS_W'(i);
      it.ch = 1'($urandom_range(0, 1));
      it.smp = SMP_W'($urandom);
      it.weight = draw_wgt();
      send_item(it, CHK_MODEL, blank_out);
    end
    accepted_count += FRAME_MAX;

    run_phase(1'b1);
    while (accepted_count < ITEM_TARGET) run_phase(1'b0);

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/wola_pkg.sv
design/weighted_overlap_add_synthesis.sv
sim/testbench.sv
